// ----- rtl/core/swfd_pkg.sv -----
package swfd_pkg;

    // Sync word and field widths
    localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND   = 8'h55;
    localparam int          LEN_W         = 16;
    localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd260;
    localparam logic [LEN_W-1:0] LEN_MAX     = 16'hFFFF;

    // Receiver mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_HELD  = 2'd1,
        MODE_FRAME = 2'd2
    } mode_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_relay;
        logic       last_of_run;
    } result_t;

    // Results caused by one input beat
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

endpackage

// ----- rtl/core/swfd_step.sv -----
module swfd_step (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   take,
    input  logic [7:0]             data_byte,
    input  logic                   host_connected,
    output swfd_pkg::step_t        step
);
    import swfd_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [1:0]       header_count_reg, header_count_next;
    logic [7:0]       length_high_reg, length_high_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0] payload_limit_reg;

    logic [LEN_W-1:0] plen;
    logic [LEN_W:0]   plen_sum;
    logic [LEN_W-1:0] left_dec;

    assign plen     = {length_high_reg, data_byte};
    assign plen_sum = {1'b0, plen} + 17'd2;
    assign left_dec = bytes_left_reg - 16'd1;

    // Decide results and next state for the beat on the input
    always_comb begin
        mode_next         = mode_reg;
        header_count_next = header_count_reg;
        length_high_next  = length_high_reg;
        bytes_left_next   = bytes_left_reg;
        step              = '0;
        step.first        = '{out_byte: data_byte, to_relay: 1'b0, last_of_run: 1'b1};
        step.count        = 2'd1;

        if (!host_connected) begin
            mode_next = MODE_IDLE;
        end else begin
            case (mode_reg)
                MODE_HELD: begin
                    step.count  = 2'd2;
                    step.first  = '{out_byte: SYNC_FIRST, to_relay: 1'b0, last_of_run: 1'b0};
                    step.second = '{out_byte: data_byte, to_relay: 1'b0, last_of_run: 1'b1};
                    mode_next   = MODE_IDLE;
                    if (data_byte == SYNC_SECOND) begin
                        step.first.to_relay  = 1'b1;
                        step.second.to_relay = 1'b1;
                        mode_next            = MODE_FRAME;
                        header_count_next    = 2'd0;
                    end
                end
                MODE_FRAME: begin
                    step.first.to_relay = 1'b1;
                    if (header_count_reg == 2'd0) begin
                        length_high_next  = data_byte;
                        header_count_next = 2'd1;
                    end else if (header_count_reg == 2'd1) begin
                        header_count_next = 2'd2;
                        if (plen > payload_limit_reg) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            // saturate length plus CRC
                            bytes_left_next = plen_sum[LEN_W] ? LEN_MAX : plen_sum[LEN_W-1:0];
                        end
                    end else if (bytes_left_reg == '0) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        bytes_left_next = left_dec;
                        if (left_dec == '0) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                    if (data_byte == SYNC_FIRST) begin
                        mode_next  = MODE_HELD;
                        step.count = 2'd0;
                    end
                end
            endcase
        end
    end

    // Advance state on an accepted beat; capture config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            header_count_reg  <= 2'd0;
            length_high_reg   <= 8'd0;
            bytes_left_reg    <= '0;
            payload_limit_reg <= LIMIT_RESET;
        end else begin
            if (cfg_we) begin
                payload_limit_reg <= cfg_wdata;
            end
            if (take) begin
                mode_reg         <= mode_next;
                header_count_reg <= header_count_next;
                length_high_reg  <= length_high_next;
                bytes_left_reg   <= bytes_left_next;
            end
        end
    end

endmodule

// ----- rtl/core/swfd_out.sv -----
module swfd_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  swfd_pkg::step_t        step,
    output logic                   room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output swfd_pkg::result_t      m_result
);
    import swfd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t out_reg, out_next;
    result_t pend_reg, pend_next;
    logic    pop;

    assign pop      = out_valid_reg && m_ready;
    assign room     = !pend_valid_reg && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    // Move pending beat forward, or load fresh results
    always_comb begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg && pop) begin
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end else if (push && step.count != 2'd0) begin
            out_valid_next = 1'b1;
            out_next       = step.first;
            if (step.count == 2'd2) begin
                pend_valid_next = 1'b1;
                pend_next       = step.second;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold result beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

// ----- rtl/core/sync_word_frame_demux.sv -----
// Channel | Direction | Beat fields
// s_      | in        | s_data_byte[7:0], s_host_connected
// m_      | out       | m_out_byte[7:0], m_to_relay, m_last_of_run
// cfg_    | in        | cfg_wdata[15:0] (payload_limit), written when cfg_we
//
// One input beat per cycle while s_ready is high; results are registered and appear in the cycle after acceptance.
// A beat that yields two results (sync word or replayed 0xAA) drops s_ready
// until the second result moves from the pending slot into the output stage.
// Reset (aresetn low, synchronous) clears mode and counters, limit to 260.
// Stalls on m_ready pass straight back to s_ready through the output stage.
module sync_word_frame_demux (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_host_connected,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_to_relay,
    output logic        m_last_of_run
);
    import swfd_pkg::*;

    step_t   step;
    result_t result;
    logic    room;
    logic    take;

    assign s_ready = room;
    assign take    = s_valid && room;

    // Per-beat decode and framing state
    swfd_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .take           (take),
        .data_byte      (s_data_byte),
        .host_connected (s_host_connected),
        .step           (step)
    );

    // Result register with one pending slot
    swfd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (take),
        .step     (step),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_out_byte    = result.out_byte;
    assign m_to_relay    = result.to_relay;
    assign m_last_of_run = result.last_of_run;

endmodule

// ----- rtl/core/swfd_checker.sv -----
module swfd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_host_connected,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_to_relay,
    input  logic        m_last_of_run
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_to_relay) && $stable(m_last_of_run))
        else $error("stalled result beat changed");

    // Reset empties the output stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Disconnected beat passes straight to the command path
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_host_connected && (!m_valid || m_ready)
            |=> m_valid && m_out_byte == $past(s_data_byte)
                && !m_to_relay && m_last_of_run)
        else $error("disconnected beat not passed through");

    // First of a pair is followed at once by the closing beat
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run)
        else $error("result pair broken");

    // Hold off input while the first of a pair is still on the output
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input accepted with a result pair in the output stage");

endmodule

bind sync_word_frame_demux swfd_checker u_swfd_checker (.*);
